// ===== sv/spwm_pkg.sv =====
package spwm_pkg;

  // Sine table and timing constants
  localparam int POINTS     = 181;
  localparam int IDX_W      = $clog2(POINTS);
  localparam int TICKS_BASE = 16972;
  localparam int PERIOD_W   = 15;
  localparam int MAX_FREQ   = 200;
  localparam int DIV_CNT_W  = $clog2(PERIOD_W);

  // Field widths
  localparam int AMP_W      = 8;
  localparam int FREQ_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Fixed point: Q1.15 sine (0.5 -> 16384), Q2.14 gain
  localparam int GAIN_Q14   = 19661;
  localparam int GAIN_W     = AMP_W + 15;
  localparam int SINE_W     = 16;
  localparam int PROD_W     = GAIN_W + 1 + SINE_W;
  localparam int MID_LEVEL  = 127;
  localparam int DUTY_SHIFT = 29;
  localparam logic signed [PROD_W-1:0] MID_Q29 = PROD_W'(MID_LEVEL) << DUTY_SHIFT;

  // Start delays of phases B and C, in sample events
  localparam int DELAY_B    = 2 * POINTS / 3;
  localparam int DELAY_C    = POINTS / 3;
  localparam int DELAY_W    = $clog2(DELAY_B + 1);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor series denominators (2j)*(2j+1) for j = 1..8
  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE = 1'b0,
    REG_FREQUENCY = 1'b1
  } cfg_reg_t;

  typedef logic signed [SINE_W-1:0] sine_rom_t [POINTS];

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] freq;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] quotient;
  } div_rsp_t;

  // sin(2*pi*k/POINTS)/2 in Q1.15, Q30 Taylor series on the folded angle
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   a;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   r;
    longint            sum;
    logic              neg;
    for (int k = 0; k < POINTS; k++) begin
      a   = 4 * k;
      neg = 1'b0;
      if (a >= 2 * POINTS) begin
        a   = a - 2 * POINTS;
        neg = 1'b1;
      end
      if (a > POINTS) a = 2 * POINTS - a;
      x    = HALF_PI_Q30 * a / POINTS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j <= 8; j++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[j-1];
        if ((j & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 32768) >> 16;
      rom[k] = neg ? -SINE_W'(r) : SINE_W'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== sv/spwm_period_div.sv =====
// Restoring divider: TICKS_BASE / min(freq, MAX_FREQ), one quotient bit per cycle
module spwm_period_div (
  input  logic               clk,
  input  logic               rst,
  input  spwm_pkg::div_req_t req,
  output spwm_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic                             done;
  logic [spwm_pkg::DIV_CNT_W-1:0]   count;
  logic [spwm_pkg::PERIOD_W-1:0]    dq;
  logic [spwm_pkg::FREQ_W-1:0]      rem;
  logic [spwm_pkg::FREQ_W-1:0]      divisor;
  logic [spwm_pkg::FREQ_W-1:0]      freq_sat;
  logic [spwm_pkg::FREQ_W:0]        trial;
  logic [spwm_pkg::FREQ_W:0]        diff;
  logic                             ge;
  logic                             last;

  assign freq_sat = (req.freq > spwm_pkg::FREQ_W'(spwm_pkg::MAX_FREQ)) ?
                    spwm_pkg::FREQ_W'(spwm_pkg::MAX_FREQ) : req.freq;
  assign trial    = {rem, dq[spwm_pkg::PERIOD_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign last     = count == spwm_pkg::DIV_CNT_W'(spwm_pkg::PERIOD_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else if (busy) begin
      busy  <= !last;
      done  <= last;
      count <= count + 1'b1;
    end else begin
      done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq      <= spwm_pkg::PERIOD_W'(spwm_pkg::TICKS_BASE);
      rem     <= '0;
      divisor <= freq_sat;
    end else if (busy) begin
      dq  <= {dq[spwm_pkg::PERIOD_W-2:0], ge};
      rem <= ge ? diff[spwm_pkg::FREQ_W-1:0] : trial[spwm_pkg::FREQ_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

// ===== sv/spwm_duty_calc.sv =====
// Shared gain multiply, then offset and clamp to 8 bits
module spwm_duty_calc (
  input  logic                               clk,
  input  logic                               load,
  input  logic [spwm_pkg::GAIN_W-1:0]        gain,
  input  logic signed [spwm_pkg::SINE_W-1:0] sine,
  output logic [spwm_pkg::DUTY_W-1:0]        duty
);

  logic signed [spwm_pkg::PROD_W-1:0] product;
  logic signed [spwm_pkg::PROD_W-1:0] level;

  always_ff @(posedge clk) begin
    if (load) product <= $signed({1'b0, gain}) * sine;
  end

  assign level = product + spwm_pkg::MID_Q29;

  always_comb begin
    if (level[spwm_pkg::PROD_W-1]) begin
      duty = '0;
    end else if (|level[spwm_pkg::PROD_W-2:spwm_pkg::DUTY_SHIFT+spwm_pkg::DUTY_W]) begin
      duty = '1;
    end else begin
      duty = level[spwm_pkg::DUTY_SHIFT+spwm_pkg::DUTY_W-1:spwm_pkg::DUTY_SHIFT];
    end
  end

endmodule

// ===== sv/three_phase_sine_pwm_generator.sv =====
// Three-phase sine PWM compare-value generator. Each input item is one
// generator tick (advance=1) or an idle slot (advance=0), and each gives
// exactly one result item unless a divider launch cuts off its sample
// event. A tick counter fires a sample event every
// 16972/min(frequency, 200) + 1 ticks; on an event phase A steps through
// a 181-point half-scale sine and phases B and C join after 120 and 60
// events. Duties are clamp(127 + 1.2*amplitude*sin/2) with saturation
// at 0 and 255. With amplitude or frequency at zero the block is closed:
// duties read 0 and closed reads 1. A tick without a sample event has its
// result registered in the cycle after it is accepted. A sample event
// runs the stepping phases one after another through a single shared
// multiplier, a multiply and an accumulate state per phase, then a done
// state, with in_ready low throughout. After reset, after a write that
// reopens the block and after a frequency write that leaves it open, the
// 15-step serial divider holds in_ready low while it rebuilds the sample
// period. Configuration writes are taken at any cycle without a handshake.
module three_phase_sine_pwm_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            advance,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [spwm_pkg::DUTY_W-1:0]     duty_a,
  output logic [spwm_pkg::DUTY_W-1:0]     duty_b,
  output logic [spwm_pkg::DUTY_W-1:0]     duty_c,
  output logic                            closed,
  output logic                            sample_event
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic                              boot;
  logic [spwm_pkg::AMP_W-1:0]        amplitude;
  logic [spwm_pkg::FREQ_W-1:0]       frequency;
  logic [spwm_pkg::GAIN_W-1:0]       gain_amp;
  logic [spwm_pkg::PERIOD_W-1:0]     tick_counter;
  logic [spwm_pkg::PERIOD_W-1:0]     sample_period;
  logic [spwm_pkg::IDX_W-1:0]        phase_index [3];
  logic [spwm_pkg::DELAY_W-1:0]      delay_cnt [2];
  logic [spwm_pkg::DUTY_W-1:0]       duty_hold [3];
  logic [2:0]                        step_mask;
  logic [1:0]                        phase_sel;
  logic [1:0]                        phase_sel_next;
  logic                              more_phases;

  logic                              accept;
  logic                              closed_now;
  logic                              tick_go;
  logic                              fire;
  logic                              step_b;
  logic                              step_c;

  logic [spwm_pkg::AMP_W-1:0]        amp_new;
  logic [spwm_pkg::FREQ_W-1:0]       freq_new;
  logic                              closed_new;
  logic                              cfg_clear;
  logic                              cfg_restart;
  logic                              cfg_period;

  spwm_pkg::div_req_t                div_req;
  spwm_pkg::div_rsp_t                div_rsp;
  logic signed [spwm_pkg::SINE_W-1:0] sine_val;
  logic [spwm_pkg::DUTY_W-1:0]       calc_duty;

  function automatic logic [spwm_pkg::IDX_W-1:0] next_index(
    input logic [spwm_pkg::IDX_W-1:0] i
  );
    return (i == spwm_pkg::IDX_W'(spwm_pkg::POINTS - 1)) ? '0 : i + 1'b1;
  endfunction

  // Handshake and sample timing
  assign in_ready   = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign closed_now = (amplitude == '0) || (frequency == '0);
  assign tick_go    = accept && advance && !closed_now;
  assign fire       = tick_go && (tick_counter >= sample_period);
  assign step_b     = delay_cnt[0] >= spwm_pkg::DELAY_W'(spwm_pkg::DELAY_B);
  assign step_c     = delay_cnt[1] >= spwm_pkg::DELAY_W'(spwm_pkg::DELAY_C);

  // Config decode: closing clears duties, reopening restarts everything,
  // a frequency change while open only rebuilds the period
  assign amp_new     = (cfg_write && spwm_pkg::cfg_reg_t'(cfg_index) == spwm_pkg::REG_AMPLITUDE)
                       ? cfg_data : amplitude;
  assign freq_new    = (cfg_write && spwm_pkg::cfg_reg_t'(cfg_index) == spwm_pkg::REG_FREQUENCY)
                       ? cfg_data : frequency;
  assign closed_new  = (amp_new == '0) || (freq_new == '0);
  assign cfg_clear   = cfg_write && closed_new;
  assign cfg_restart = cfg_write && !closed_new && closed_now;
  assign cfg_period  = cfg_write && !closed_new && !closed_now &&
                       spwm_pkg::cfg_reg_t'(cfg_index) == spwm_pkg::REG_FREQUENCY;

  assign div_req.start = boot || cfg_restart || cfg_period;
  assign div_req.freq  = freq_new;

  spwm_period_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign sine_val = spwm_pkg::SINE_ROM[phase_index[phase_sel]];

  spwm_duty_calc u_calc (
    .clk  (clk),
    .load (state == ST_MUL),
    .gain (gain_amp),
    .sine (sine_val),
    .duty (calc_duty)
  );

  // Next stepping phase after the current one
  always_comb begin
    more_phases    = 1'b1;
    phase_sel_next = phase_sel;
    if (phase_sel == 2'd0 && step_mask[1]) begin
      phase_sel_next = 2'd1;
    end else if (phase_sel != 2'd2 && step_mask[2]) begin
      phase_sel_next = 2'd2;
    end else begin
      more_phases = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (fire) state_next = ST_MUL;
      ST_DIV:  if (div_rsp.done) state_next = ST_IDLE;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = more_phases ? ST_MUL : ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (div_req.start) state_next = ST_DIV;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_DIV;
      boot         <= 1'b1;
      amplitude    <= spwm_pkg::AMP_W'(255);
      frequency    <= spwm_pkg::FREQ_W'(spwm_pkg::MAX_FREQ);
      tick_counter <= '0;
      out_valid    <= 1'b0;
      step_mask    <= '0;
      phase_sel    <= '0;
      for (int p = 0; p < 3; p++) begin
        phase_index[p] <= '0;
        duty_hold[p]   <= '0;
      end
      for (int d = 0; d < 2; d++) delay_cnt[d] <= '0;
    end else begin
      state <= state_next;
      boot  <= 1'b0;

      if (out_valid && out_ready) out_valid <= 1'b0;
      if ((accept && !fire) || state == ST_DONE) out_valid <= 1'b1;

      if (tick_go) tick_counter <= fire ? '0 : tick_counter + 1'b1;

      if (fire) begin
        phase_index[0] <= next_index(phase_index[0]);
        if (step_b) phase_index[1] <= next_index(phase_index[1]);
        else delay_cnt[0] <= delay_cnt[0] + 1'b1;
        if (step_c) phase_index[2] <= next_index(phase_index[2]);
        else delay_cnt[1] <= delay_cnt[1] + 1'b1;
        step_mask <= {step_c, step_b, 1'b1};
        phase_sel <= '0;
      end

      if (state == ST_ACC) begin
        duty_hold[phase_sel] <= calc_duty;
        phase_sel            <= phase_sel_next;
      end

      if (cfg_write) begin
        amplitude <= amp_new;
        frequency <= freq_new;
      end
      if (cfg_clear) begin
        for (int p = 0; p < 3; p++) duty_hold[p] <= '0;
      end
      if (cfg_restart) begin
        tick_counter <= '0;
        for (int p = 0; p < 3; p++) begin
          phase_index[p] <= '0;
          duty_hold[p]   <= '0;
        end
        for (int d = 0; d < 2; d++) delay_cnt[d] <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    gain_amp <= spwm_pkg::GAIN_W'(amplitude) * spwm_pkg::GAIN_W'(spwm_pkg::GAIN_Q14);
    if (div_rsp.done) sample_period <= div_rsp.quotient;
    if (accept && !fire) begin
      duty_a       <= closed_now ? '0 : duty_hold[0];
      duty_b       <= closed_now ? '0 : duty_hold[1];
      duty_c       <= closed_now ? '0 : duty_hold[2];
      closed       <= closed_now;
      sample_event <= 1'b0;
    end else if (state == ST_DONE) begin
      duty_a       <= duty_hold[0];
      duty_b       <= duty_hold[1];
      duty_c       <= duty_hold[2];
      closed       <= 1'b0;
      sample_event <= 1'b1;
    end
  end

  a_closed_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && closed |-> duty_a == '0 && duty_b == '0 && duty_c == '0 && !sample_event)
    else $error("closed item carries nonzero duty or event");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    phase_index[0] < spwm_pkg::IDX_W'(spwm_pkg::POINTS) &&
    phase_index[1] < spwm_pkg::IDX_W'(spwm_pkg::POINTS) &&
    phase_index[2] < spwm_pkg::IDX_W'(spwm_pkg::POINTS))
    else $error("phase index out of table");

  a_b_waits: assert property (@(posedge clk) disable iff (rst)
    phase_index[1] != '0 |-> delay_cnt[0] == spwm_pkg::DELAY_W'(spwm_pkg::DELAY_B))
    else $error("phase B stepped before its start delay");

  a_c_waits: assert property (@(posedge clk) disable iff (rst)
    phase_index[2] != '0 |-> delay_cnt[1] == spwm_pkg::DELAY_W'(spwm_pkg::DELAY_C))
    else $error("phase C stepped before its start delay");

  a_plain_tick: assert property (@(posedge clk) disable iff (rst)
    accept && !fire |=> out_valid && state == ST_IDLE || div_req.start || state == ST_DIV)
    else $error("tick without sample event not delivered next cycle");

endmodule
